// File: rtl/tcon_pkg.sv
// shared constants, codes and controller/datapath interface types for the text console
package tcon_pkg;

    localparam int SCREEN_WIDTH   = 80;
    localparam int SCREEN_HEIGHT  = 25;
    localparam int TERMINAL_COUNT = 4;

    localparam int CELLS_PER_TERM = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int TOTAL_CELLS    = TERMINAL_COUNT * CELLS_PER_TERM;
    localparam int ADDR_W         = $clog2(TOTAL_CELLS);
    localparam int ROW_W          = $clog2(SCREEN_HEIGHT);
    localparam int TERM_W         = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] TAB_STEP   = 8'h04;
    localparam logic [7:0] TAB_MASK   = 8'hFC;

    typedef enum logic [2:0] {
        OP_PUT        = 3'd0,
        OP_CLEAR      = 3'd1,
        OP_SWITCH     = 3'd2,
        OP_SET_ROW    = 3'd3,
        OP_SET_COLUMN = 3'd4,
        OP_READ       = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        CUR_HOLD,
        CUR_NEWLINE,
        CUR_CR,
        CUR_TAB,
        CUR_HOME_LAST,
        CUR_ADVANCE,
        CUR_SET_ROW,
        CUR_SET_COL,
        CUR_CLEAR,
        CUR_SWITCH
    } cursor_op_t;

    typedef enum logic [3:0] {
        ST_INIT_START,
        ST_INIT_FILL,
        ST_IDLE,
        ST_DECODE,
        ST_WRITE_CHAR,
        ST_SCROLL_COPY,
        ST_SCROLL_DRAIN,
        ST_SCROLL_BLANK,
        ST_CLEAR_FILL,
        ST_READ_WAIT,
        ST_SEND_CURSOR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       latch;
        cursor_op_t cursor;
        logic       cursor_send;
        logic       init_start;
        logic       scroll_start;
        logic       clear_start;
        logic       copy_read;
        logic       fill;
        logic       zero_fill;
        logic       write_char;
        logic       read_cell;
        logic       capture_data;
        logic       load_result;
    } tcon_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       is_lf;
        logic       is_cr;
        logic       is_tab;
        logic       col_past_end;
        logic       row_at_bottom;
        logic       switch_ok;
        logic       addr_ok;
        logic       rd_last;
        logic       wr_last;
    } tcon_status_t;

endpackage

// File: rtl/tcon_ctrl.sv
// sequencing state machine for the text console
module tcon_ctrl import tcon_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  tcon_status_t status,
    output tcon_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   write_after_scroll_reg;
    logic   write_after_scroll_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= ST_INIT_START;
            write_after_scroll_reg <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            state_reg              <= state_next;
            write_after_scroll_reg <= write_after_scroll_next;
            out_valid_reg          <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next              = state_reg;
        write_after_scroll_next = write_after_scroll_reg;
        out_valid_next          = out_valid_reg && out_stall;
        cmd                     = '0;
        cmd.cursor              = CUR_HOLD;

        unique case (state_reg)
            ST_INIT_START:
            begin
                cmd.init_start = 1'b1;
                state_next     = ST_INIT_FILL;
            end
            ST_INIT_FILL:
            begin
                cmd.fill      = 1'b1;
                cmd.zero_fill = 1'b1;
                if (status.wr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FINISH;
                unique case (status.op)
                    OP_PUT:
                    begin
                        priority if (status.is_lf)
                        begin
                            if (status.row_at_bottom)
                            begin
                                cmd.cursor              = CUR_HOME_LAST;
                                cmd.scroll_start        = 1'b1;
                                write_after_scroll_next = 1'b0;
                                state_next              = ST_SCROLL_COPY;
                            end
                            else
                            begin
                                cmd.cursor = CUR_NEWLINE;
                            end
                        end
                        else if (status.is_cr)
                        begin
                            cmd.cursor = CUR_CR;
                        end
                        else if (status.is_tab)
                        begin
                            cmd.cursor = CUR_TAB;
                        end
                        else if (status.col_past_end && status.row_at_bottom)
                        begin
                            cmd.cursor              = CUR_HOME_LAST;
                            cmd.scroll_start        = 1'b1;
                            write_after_scroll_next = 1'b1;
                            state_next              = ST_SCROLL_COPY;
                        end
                        else if (status.col_past_end)
                        begin
                            cmd.cursor = CUR_NEWLINE;
                            state_next = ST_WRITE_CHAR;
                        end
                        else
                        begin
                            state_next = ST_WRITE_CHAR;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.cursor      = CUR_CLEAR;
                        cmd.clear_start = 1'b1;
                        state_next      = ST_CLEAR_FILL;
                    end
                    OP_SWITCH:
                    begin
                        if (status.switch_ok)
                        begin
                            cmd.cursor = CUR_SWITCH;
                            state_next = ST_SEND_CURSOR;
                        end
                    end
                    OP_SET_ROW:
                    begin
                        cmd.cursor = CUR_SET_ROW;
                    end
                    OP_SET_COLUMN:
                    begin
                        cmd.cursor = CUR_SET_COL;
                    end
                    OP_READ:
                    begin
                        if (status.addr_ok)
                        begin
                            cmd.read_cell = 1'b1;
                            state_next    = ST_READ_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_WRITE_CHAR:
            begin
                cmd.write_char = 1'b1;
                cmd.cursor     = CUR_ADVANCE;
                state_next     = ST_FINISH;
            end
            ST_SCROLL_COPY:
            begin
                cmd.copy_read = 1'b1;
                if (status.rd_last)
                begin
                    state_next = ST_SCROLL_DRAIN;
                end
            end
            ST_SCROLL_DRAIN:
            begin
                state_next = ST_SCROLL_BLANK;
            end
            ST_SCROLL_BLANK:
            begin
                cmd.fill = 1'b1;
                if (status.wr_last)
                begin
                    state_next = write_after_scroll_reg ? ST_WRITE_CHAR : ST_FINISH;
                end
            end
            ST_CLEAR_FILL:
            begin
                cmd.fill = 1'b1;
                if (status.wr_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ_WAIT:
            begin
                cmd.capture_data = 1'b1;
                state_next       = ST_FINISH;
            end
            ST_SEND_CURSOR:
            begin
                cmd.cursor_send = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/tcon_datapath.sv
// cell memory, cursor registers, sweep pointers and result register of the text console
module tcon_datapath import tcon_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  tcon_cmd_t    cmd,
    output tcon_status_t status,
    input  logic [2:0]   operation,
    input  logic [7:0]   value,
    input  logic [10:0]  cell_address,
    input  logic         cfg_write_enable,
    input  logic [7:0]   cfg_write_data,
    output logic [4:0]   cursor_row_out,
    output logic [7:0]   cursor_column_out,
    output logic [1:0]   active_terminal,
    output logic [11:0]  hardware_cursor_position,
    output logic [15:0]  cell_data
);

    logic [15:0]       cell_mem [TOTAL_CELLS];
    logic [15:0]       rdata_reg;

    logic [2:0]        op_reg;
    logic [7:0]        val_reg;
    logic [10:0]       addr_reg;
    logic [15:0]       data_reg;
    logic [15:0]       data_next;
    logic [7:0]        attr_reg;

    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [7:0]        col_reg;
    logic [7:0]        col_next;
    logic [TERM_W-1:0] shown_reg;
    logic [TERM_W-1:0] shown_next;
    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] base_next;
    logic [11:0]       disp_reg;
    logic [11:0]       disp_next;
    logic [ROW_W-1:0]  saved_rows_reg [TERMINAL_COUNT];
    logic [7:0]        saved_cols_reg [TERMINAL_COUNT];

    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_next;
    logic [ADDR_W-1:0] wr_ptr_reg;
    logic [ADDR_W-1:0] wr_ptr_next;
    logic [ADDR_W-1:0] last_reg;
    logic [ADDR_W-1:0] last_next;
    logic              copy_valid_reg;

    logic [TERM_W-1:0] val_term;
    logic [ADDR_W-1:0] cursor_index;
    logic [31:0]       cursor_position;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic [4:0]        res_row_reg;
    logic [7:0]        res_col_reg;
    logic [1:0]        res_term_reg;
    logic [11:0]       res_disp_reg;
    logic [15:0]       res_data_reg;

    assign val_term        = val_reg[TERM_W-1:0];
    assign cursor_index    = ADDR_W'(row_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_reg);
    assign cursor_position = 32'(row_reg) * 32'(SCREEN_WIDTH) + 32'(col_reg);

    assign status.op            = op_reg;
    assign status.is_lf         = (val_reg == CHAR_LF);
    assign status.is_cr         = (val_reg == CHAR_CR);
    assign status.is_tab        = (val_reg == CHAR_TAB);
    assign status.col_past_end  = (col_reg >= 8'(SCREEN_WIDTH));
    assign status.row_at_bottom = (row_reg == ROW_W'(SCREEN_HEIGHT - 1));
    assign status.switch_ok     = (val_reg < 8'(TERMINAL_COUNT)) && (val_term != shown_reg);
    assign status.addr_ok       = (32'(addr_reg) < 32'(CELLS_PER_TERM));
    assign status.rd_last       = (rd_ptr_reg == last_reg);
    assign status.wr_last       = (wr_ptr_reg == last_reg);

    // cell memory ports
    always_comb
    begin
        mem_we    = copy_valid_reg || cmd.fill || cmd.write_char;
        mem_waddr = (copy_valid_reg || cmd.fill) ? wr_ptr_reg : base_reg + cursor_index;
        priority if (copy_valid_reg)
        begin
            mem_wdata = rdata_reg;
        end
        else if (cmd.fill)
        begin
            mem_wdata = cmd.zero_fill ? 16'h0000 : {attr_reg, BLANK_CHAR};
        end
        else
        begin
            mem_wdata = {attr_reg, val_reg};
        end
        mem_re    = cmd.copy_read || cmd.read_cell;
        mem_raddr = cmd.read_cell ? base_reg + ADDR_W'(addr_reg) : rd_ptr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= cell_mem[mem_raddr];
        end
    end

    // sweep pointers
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        last_next   = last_reg;
        priority if (cmd.init_start)
        begin
            wr_ptr_next = '0;
            last_next   = ADDR_W'(TOTAL_CELLS - 1);
        end
        else if (cmd.scroll_start)
        begin
            rd_ptr_next = base_reg + ADDR_W'(SCREEN_WIDTH);
            wr_ptr_next = base_reg;
            last_next   = base_reg + ADDR_W'(CELLS_PER_TERM - 1);
        end
        else if (cmd.clear_start)
        begin
            wr_ptr_next = base_reg;
            last_next   = base_reg + ADDR_W'(CELLS_PER_TERM - 1);
        end
        else
        begin
            if (cmd.copy_read)
            begin
                rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
            end
            if (copy_valid_reg || cmd.fill)
            begin
                wr_ptr_next = wr_ptr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            last_reg       <= '0;
            copy_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            last_reg       <= last_next;
            copy_valid_reg <= cmd.copy_read;
        end
    end

    // cursor and terminal state
    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        shown_next = shown_reg;
        base_next  = base_reg;
        disp_next  = disp_reg;
        unique case (cmd.cursor)
            CUR_HOLD:
            begin
                row_next = row_reg;
            end
            CUR_NEWLINE:
            begin
                row_next = row_reg + ROW_W'(1);
                col_next = 8'd0;
            end
            CUR_CR:
            begin
                col_next = 8'd0;
            end
            CUR_TAB:
            begin
                col_next = (col_reg + TAB_STEP) & TAB_MASK;
            end
            CUR_HOME_LAST:
            begin
                row_next = ROW_W'(SCREEN_HEIGHT - 1);
                col_next = 8'd0;
            end
            CUR_ADVANCE:
            begin
                col_next = col_reg + 8'd1;
            end
            CUR_SET_ROW:
            begin
                if (val_reg < 8'(SCREEN_HEIGHT))
                begin
                    row_next = ROW_W'(val_reg);
                end
            end
            CUR_SET_COL:
            begin
                if (val_reg < 8'(SCREEN_WIDTH))
                begin
                    col_next = val_reg;
                end
            end
            CUR_CLEAR:
            begin
                row_next  = '0;
                col_next  = 8'd0;
                disp_next = 12'd0;
            end
            CUR_SWITCH:
            begin
                shown_next = val_term;
                base_next  = ADDR_W'(val_term) * ADDR_W'(CELLS_PER_TERM);
                row_next   = saved_rows_reg[val_term];
                col_next   = saved_cols_reg[val_term];
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
        if (cmd.cursor_send)
        begin
            disp_next = cursor_position[11:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= 8'd0;
            shown_reg <= '0;
            base_reg  <= '0;
            disp_reg  <= 12'd0;
            attr_reg  <= ATTR_RESET;
            for (int i = 0; i < TERMINAL_COUNT; i++)
            begin
                saved_rows_reg[i] <= '0;
                saved_cols_reg[i] <= 8'd0;
            end
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            shown_reg <= shown_next;
            base_reg  <= base_next;
            disp_reg  <= disp_next;
            if (cfg_write_enable)
            begin
                attr_reg <= cfg_write_data;
            end
            if (cmd.cursor == CUR_SWITCH)
            begin
                saved_rows_reg[shown_reg] <= row_reg;
                saved_cols_reg[shown_reg] <= col_reg;
            end
        end
    end

    // operand capture and result register
    always_comb
    begin
        data_next = data_reg;
        priority if (cmd.latch)
        begin
            data_next = 16'h0000;
        end
        else if (cmd.capture_data)
        begin
            data_next = rdata_reg;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (cmd.latch)
        begin
            op_reg   <= operation;
            val_reg  <= value;
            addr_reg <= cell_address;
        end
        if (cmd.load_result)
        begin
            res_row_reg  <= 5'(row_reg);
            res_col_reg  <= col_reg;
            res_term_reg <= 2'(shown_reg);
            res_disp_reg <= disp_reg;
            res_data_reg <= data_reg;
        end
    end

    assign cursor_row_out           = res_row_reg;
    assign cursor_column_out        = res_col_reg;
    assign active_terminal          = res_term_reg;
    assign hardware_cursor_position = res_disp_reg;
    assign cell_data                = res_data_reg;

endmodule

// File: rtl/text_console_with_terminals.sv
// top level of the multi-terminal text console
//
// Input channel (in_valid/in_stall) carries one operation with value and
// cell_address; each transfer yields exactly one result on the output
// channel (out_valid/out_stall) with the cursor, active terminal, display
// cursor position and, for a cell read, the cell contents.
// Items are handled one at a time. A printable character is captured,
// decoded, written to the cell memory and then loaded as a result;
// control characters and cursor moves skip the memory write, a valid
// switch adds a step that loads the display cursor, and a cell read adds
// a memory read unless the address is out of range. A scroll copies the
// lower rows of the active terminal up one row, one cell per cycle,
// reading one cell while writing the one read before it, then blanks the
// last row; clear blanks the whole active terminal.
// After reset the whole cell memory is zeroed one entry per cycle, with
// in_stall high; attribute writes are taken at any time.
// The result sits in an output register, so the next item is taken while a
// result waits; if the receiver stalls, the following result holds its
// finished state until the register frees.
module text_console_with_terminals import tcon_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [7:0]  value,
    input  logic [10:0] cell_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  cursor_row_out,
    output logic [7:0]  cursor_column_out,
    output logic [1:0]  active_terminal,
    output logic [11:0] hardware_cursor_position,
    output logic [15:0] cell_data,
    input  logic        cfg_write_enable,
    input  logic [7:0]  cfg_write_data
);

    tcon_cmd_t    cmd;
    tcon_status_t status;

    tcon_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tcon_datapath u_datapath (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .cmd                      (cmd),
        .status                   (status),
        .operation                (operation),
        .value                    (value),
        .cell_address             (cell_address),
        .cfg_write_enable         (cfg_write_enable),
        .cfg_write_data           (cfg_write_data),
        .cursor_row_out           (cursor_row_out),
        .cursor_column_out        (cursor_column_out),
        .active_terminal          (active_terminal),
        .hardware_cursor_position (hardware_cursor_position),
        .cell_data                (cell_data)
    );

`ifndef SYNTHESIS
    a_transfer_latches: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> cmd.latch && !cmd.fill && !cmd.copy_read)
        else $error("input transfer not captured or taken during a sweep");

    a_one_mem_access: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.fill, cmd.copy_read, cmd.write_char, cmd.read_cell}))
        else $error("conflicting cell memory commands");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(cursor_row_out) < 32'(SCREEN_HEIGHT))
        else $error("cursor row beyond screen height");

    a_result_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid)
        else $error("loaded result not presented");
`endif

endmodule

// File: test/text_console_with_terminals_tb.sv
// self-checking testbench for the text console: directed and random traffic against a shadow model
module text_console_with_terminals_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcon_pkg::*;

    localparam logic [2:0] OP_SPARE_LOW  = 3'd6;
    localparam logic [2:0] OP_SPARE_HIGH = 3'd7;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  val;
        logic [10:0] addr;
    } console_req_t;

    typedef struct packed {
        logic [4:0]  row;
        logic [7:0]  col;
        logic [1:0]  term;
        logic [11:0] hw;
        logic [15:0] data;
    } console_view_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  operation = '0;
    logic [7:0]  value = '0;
    logic [10:0] cell_address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  cursor_row_out;
    logic [7:0]  cursor_column_out;
    logic [1:0]  active_terminal;
    logic [11:0] hardware_cursor_position;
    logic [15:0] cell_data;
    logic        cfg_write_enable = 1'b0;
    logic [7:0]  cfg_write_data = '0;

    // shadow copy of the console state
    logic [15:0] shadow_cells [TOTAL_CELLS];
    logic [4:0]  shadow_row;
    logic [7:0]  shadow_col;
    logic [1:0]  shadow_term;
    logic [4:0]  stored_row [TERMINAL_COUNT];
    logic [7:0]  stored_col [TERMINAL_COUNT];
    logic [11:0] shadow_hw;
    logic [7:0]  attr_shadow;

    console_req_t  pending_requests [$];
    console_view_t expected_views [$];
    console_req_t  next_req;
    console_req_t  seen_req;
    console_view_t wanted_view;

    int  issued_count = 0;
    int  accepted_count = 0;
    int  checked_count = 0;
    int  error_count = 0;
    int  idle_span = 0;
    int  send_gap = 0;
    int  stall_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  send_noisy = 1'b1;
    bit  recv_noisy = 1'b1;
    bit  quiet_run = 1'b0;
    bit  input_taken = 1'b0;

    text_console_with_terminals uut (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .in_valid                 (in_valid),
        .in_stall                 (in_stall),
        .operation                (operation),
        .value                    (value),
        .cell_address             (cell_address),
        .out_valid                (out_valid),
        .out_stall                (out_stall),
        .cursor_row_out           (cursor_row_out),
        .cursor_column_out        (cursor_column_out),
        .active_terminal          (active_terminal),
        .hardware_cursor_position (hardware_cursor_position),
        .cell_data                (cell_data),
        .cfg_write_enable         (cfg_write_enable),
        .cfg_write_data           (cfg_write_data)
    );

    always #10ns clk = ~clk;

    function automatic void scroll_shadow();
        int b;
        int i;
        b = shadow_term * CELLS_PER_TERM;
        for (i = 0; i + SCREEN_WIDTH < CELLS_PER_TERM; i++)
            shadow_cells[b + i] = shadow_cells[b + i + SCREEN_WIDTH];
        for (i = CELLS_PER_TERM - SCREEN_WIDTH; i < CELLS_PER_TERM; i++)
            shadow_cells[b + i] = {attr_shadow, BLANK_CHAR};
        shadow_row = 5'(SCREEN_HEIGHT - 1);
        shadow_col = '0;
    endfunction

    function automatic void put_shadow(logic [7:0] ch);
        int idx;
        case (ch)
            CHAR_LF:
            begin
                shadow_row = shadow_row + 5'd1;
                shadow_col = '0;
            end
            CHAR_CR:
                shadow_col = '0;
            CHAR_TAB:
                shadow_col = (shadow_col + TAB_STEP) & TAB_MASK;
            default:
            begin
                if (shadow_col >= SCREEN_WIDTH)
                begin
                    shadow_col = '0;
                    shadow_row = shadow_row + 5'd1;
                    if (shadow_row >= SCREEN_HEIGHT)
                        scroll_shadow();
                end
                idx = shadow_row * SCREEN_WIDTH + shadow_col;
                if (idx < CELLS_PER_TERM)
                    shadow_cells[shadow_term * CELLS_PER_TERM + idx] = {attr_shadow, ch};
                shadow_col = shadow_col + 8'd1;
            end
        endcase
        if (shadow_row >= SCREEN_HEIGHT)
            scroll_shadow();
    endfunction

    function automatic console_view_t apply_request(console_req_t r);
        console_view_t v;
        int b;
        int i;
        b = shadow_term * CELLS_PER_TERM;
        v.data = '0;
        case (r.opcode)
            OP_PUT:
                put_shadow(r.val);
            OP_CLEAR:
            begin
                for (i = 0; i < CELLS_PER_TERM; i++)
                    shadow_cells[b + i] = {attr_shadow, BLANK_CHAR};
                shadow_row = '0;
                shadow_col = '0;
                shadow_hw = '0;
            end
            OP_SWITCH:
                if (r.val < TERMINAL_COUNT && r.val != shadow_term)
                begin
                    stored_row[shadow_term] = shadow_row;
                    stored_col[shadow_term] = shadow_col;
                    shadow_term = r.val[1:0];
                    shadow_row = stored_row[shadow_term];
                    shadow_col = stored_col[shadow_term];
                    shadow_hw = 12'(shadow_row * SCREEN_WIDTH + shadow_col);
                end
            OP_SET_ROW:
                if (r.val < SCREEN_HEIGHT)
                    shadow_row = r.val[4:0];
            OP_SET_COLUMN:
                if (r.val < SCREEN_WIDTH)
                    shadow_col = r.val;
            OP_READ:
                if (r.addr < CELLS_PER_TERM)
                    v.data = shadow_cells[b + r.addr];
            default: ;
        endcase
        v.row  = shadow_row;
        v.col  = shadow_col;
        v.term = shadow_term;
        v.hw   = shadow_hw;
        return v;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // input and output transfers, prediction and comparison
    always @(posedge clk)
    begin
        input_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seen_req.opcode = operation;
                seen_req.val    = value;
                seen_req.addr   = cell_address;
                expected_views.push_back(apply_request(seen_req));
                accepted_count++;
                input_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_views.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end
                else
                begin
                    wanted_view = expected_views.pop_front();
                    check_field("cursor_row_out", wanted_view.row, cursor_row_out);
                    check_field("cursor_column_out", wanted_view.col, cursor_column_out);
                    check_field("active_terminal", wanted_view.term, active_terminal);
                    check_field("hardware_cursor_position", wanted_view.hw,
                                hardware_cursor_position);
                    check_field("cell_data", wanted_view.data, cell_data);
                    checked_count++;
                end
            end
        end
    end

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !input_taken)
        begin
            // stalled transfer keeps its payload
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            in_valid <= 1'b0;
        end
        else if (!quiet_run && send_noisy && $urandom_range(0, 3) == 0)
        begin
            send_gap = $urandom_range(0, 5);
            in_valid <= 1'b0;
        end
        else if (pending_requests.size() != 0)
        begin
            next_req = pending_requests.pop_front();
            operation    <= next_req.opcode;
            value        <= next_req.val;
            cell_address <= next_req.addr;
            in_valid     <= 1'b1;
        end
        else
            in_valid <= 1'b0;
        if ($urandom_range(0, 49) == 0)
            send_noisy = !send_noisy;
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && checked_count >= 60)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (stall_gap > 0)
        begin
            stall_gap--;
            out_stall <= 1'b1;
        end
        else if (!quiet_run && recv_noisy && $urandom_range(0, 3) == 0)
        begin
            stall_gap = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
        if ($urandom_range(0, 49) == 0)
            recv_noisy = !recv_noisy;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_span = 0;
        else
            idle_span++;
        if (idle_span >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_request(logic [2:0] op, logic [7:0] v, logic [10:0] a);
        console_req_t r;
        r.opcode = op;
        r.val    = v;
        r.addr   = a;
        pending_requests.push_back(r);
        issued_count++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_count != issued_count || checked_count != accepted_count);
    endtask

    task automatic write_attribute(logic [7:0] a);
        @(negedge clk);
        cfg_write_enable = 1'b1;
        cfg_write_data   = a;
        @(negedge clk);
        cfg_write_enable = 1'b0;
        attr_shadow = a;
    endtask

    function automatic logic [7:0] random_glyph();
        if ($urandom_range(0, 6) == 0)
            return 8'($urandom);
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic queue_random_phase(int count);
        int made;
        int kind;
        int run;
        int k;
        logic [7:0] pick;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                run = $urandom_range(1, 12);
                for (k = 0; k < run; k++)
                    queue_request(OP_PUT, random_glyph(), 11'($urandom));
                made += run;
            end
            else if (kind < 45)
            begin
                case ($urandom_range(0, 2))
                    0: pick = CHAR_LF;
                    1: pick = CHAR_CR;
                    default: pick = CHAR_TAB;
                endcase
                queue_request(OP_PUT, pick, 11'($urandom));
                made++;
            end
            else if (kind < 48)
            begin
                // long tab runs walk the column round its 8-bit wrap
                run = $urandom_range(20, 70);
                for (k = 0; k < run; k++)
                    queue_request(OP_PUT, CHAR_TAB, 11'($urandom));
                made += run;
            end
            else if (kind < 56)
            begin
                k = $urandom_range(0, 9);
                if (k < 4)
                    pick = 8'(SCREEN_HEIGHT - 1);
                else if (k < 7)
                    pick = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
                else
                    pick = 8'($urandom);
                queue_request(OP_SET_ROW, pick, 11'($urandom));
                made++;
            end
            else if (kind < 64)
            begin
                k = $urandom_range(0, 9);
                if (k < 5)
                    pick = 8'($urandom_range(SCREEN_WIDTH - 10, SCREEN_WIDTH - 1));
                else if (k < 7)
                    pick = 8'($urandom_range(0, SCREEN_WIDTH - 1));
                else
                    pick = 8'($urandom);
                queue_request(OP_SET_COLUMN, pick, 11'($urandom));
                made++;
            end
            else if (kind < 72)
            begin
                if ($urandom_range(0, 4) == 0)
                    pick = 8'($urandom);
                else
                    pick = 8'($urandom_range(0, TERMINAL_COUNT - 1));
                queue_request(OP_SWITCH, pick, 11'($urandom));
                made++;
            end
            else if (kind < 88)
            begin
                if ($urandom_range(0, 9) < 7)
                    queue_request(OP_READ, 8'($urandom),
                                  11'($urandom_range(0, CELLS_PER_TERM - 1)));
                else
                    queue_request(OP_READ, 8'($urandom), 11'($urandom));
                made++;
            end
            else if (kind < 91)
            begin
                queue_request(OP_CLEAR, 8'($urandom), 11'($urandom));
                made++;
            end
            else if (kind < 93)
            begin
                queue_request($urandom_range(0, 1) ? OP_SPARE_HIGH : OP_SPARE_LOW,
                              8'($urandom), 11'($urandom));
                made++;
            end
            else
            begin
                // run off the end of a line, often on the bottom row
                if ($urandom_range(0, 1) == 0)
                begin
                    queue_request(OP_SET_ROW, 8'(SCREEN_HEIGHT - 1), 11'($urandom));
                    made++;
                end
                queue_request(OP_SET_COLUMN, 8'($urandom_range(SCREEN_WIDTH - 3, SCREEN_WIDTH - 1)),
                              11'($urandom));
                run = $urandom_range(2, 4);
                for (k = 0; k < run; k++)
                    queue_request(OP_PUT, random_glyph(), 11'($urandom));
                made += run + 1;
            end
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < TOTAL_CELLS; i++)
            shadow_cells[i] = '0;
        for (i = 0; i < TERMINAL_COUNT; i++)
        begin
            stored_row[i] = '0;
            stored_col[i] = '0;
        end
        shadow_row  = '0;
        shadow_col  = '0;
        shadow_term = '0;
        shadow_hw   = '0;
        attr_shadow = ATTR_RESET;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part with the reset attribute
        queue_request(OP_READ, 8'h00, 11'd0);
        queue_request(OP_READ, 8'hFF, 11'h7FF);
        queue_request(OP_PUT, 8'h41, 11'd0);
        queue_request(OP_PUT, 8'hFF, 11'd0);
        queue_request(OP_PUT, 8'h00, 11'd0);
        queue_request(OP_PUT, CHAR_TAB, 11'd0);
        queue_request(OP_PUT, CHAR_CR, 11'd0);
        queue_request(OP_PUT, CHAR_LF, 11'd0);
        queue_request(OP_SET_COLUMN, 8'(SCREEN_WIDTH - 1), 11'd0);
        queue_request(OP_PUT, 8'h78, 11'd0);
        queue_request(OP_SET_COLUMN, 8'(SCREEN_WIDTH), 11'd0);
        queue_request(OP_SET_ROW, 8'(SCREEN_HEIGHT - 1), 11'd0);
        queue_request(OP_PUT, 8'h79, 11'd0);
        queue_request(OP_SET_ROW, 8'(SCREEN_HEIGHT), 11'd0);
        queue_request(OP_SET_ROW, 8'hFF, 11'd0);
        queue_request(OP_PUT, CHAR_LF, 11'd0);
        queue_request(OP_SWITCH, 8'd0, 11'd0);
        queue_request(OP_SWITCH, 8'(TERMINAL_COUNT), 11'd0);
        queue_request(OP_SWITCH, 8'hFF, 11'd0);
        queue_request(OP_SWITCH, 8'(TERMINAL_COUNT - 1), 11'd0);
        queue_request(OP_CLEAR, 8'd0, 11'd0);
        queue_request(OP_READ, 8'd0, 11'(CELLS_PER_TERM - 1));
        queue_request(OP_SWITCH, 8'd0, 11'd0);
        queue_request(OP_READ, 8'd0, 11'(CELLS_PER_TERM - 2 * SCREEN_WIDTH));
        queue_request(OP_SPARE_LOW, 8'h5A, 11'h2A5);
        queue_request(OP_SPARE_HIGH, 8'hA5, 11'h55A);
        wait_drained();

        write_attribute(8'hFF);
        queue_random_phase(140);
        wait_drained();

        write_attribute(8'h00);
        queue_random_phase(140);
        wait_drained();

        write_attribute(8'($urandom_range(1, 254)));
        quiet_run = 1'b1;
        queue_random_phase(125);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
